>>> rtl/acs_pkg.sv
package acs_pkg;

    localparam int CP_W = 21;
    localparam int FORM_W = 16;
    localparam int ROW_W = 6;
    localparam int N_ROWS = 36;

    localparam logic [CP_W-1:0] LAM_CP       = 21'h000644;
    localparam logic [CP_W-1:0] HAMZA_CP     = 21'h000621;
    localparam logic [CP_W-1:0] FIRST_LETTER = 21'h000621;
    localparam logic [CP_W-1:0] GAP_LOW      = 21'h00063A;
    localparam logic [CP_W-1:0] GAP_HIGH     = 21'h000641;
    localparam logic [CP_W-1:0] LAST_LETTER  = 21'h00064A;
    localparam logic [CP_W-1:0] ALEF_MADDA   = 21'h000622;
    localparam logic [CP_W-1:0] ALEF_HAMZA_A = 21'h000623;
    localparam logic [CP_W-1:0] ALEF_HAMZA_B = 21'h000625;
    localparam logic [CP_W-1:0] ALEF_CP      = 21'h000627;
    localparam logic [FORM_W-1:0] LIG_ALEF_MADDA   = 16'hFEF5;
    localparam logic [FORM_W-1:0] LIG_ALEF_HAMZA_A = 16'hFEF7;
    localparam logic [FORM_W-1:0] LIG_ALEF_HAMZA_B = 16'hFEF9;
    localparam logic [FORM_W-1:0] LIG_ALEF         = 16'hFEFB;
    localparam int ROWS_LOW = 26;

    // result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            fin;
    } t_result;

    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // columns: isolated, final, initial, medial
    localparam logic [FORM_W-1:0] FORM_TABLE [N_ROWS][4] = '{
        '{16'hFE80,16'hFE80,16'hFE80,16'hFE80}, '{16'hFE81,16'hFE82,16'hFE81,16'hFE82},
        '{16'hFE83,16'hFE84,16'hFE83,16'hFE84}, '{16'hFE85,16'hFE86,16'hFE85,16'hFE86},
        '{16'hFE87,16'hFE88,16'hFE87,16'hFE88}, '{16'hFE89,16'hFE8A,16'hFE8B,16'hFE8C},
        '{16'hFE8D,16'hFE8E,16'hFE8D,16'hFE8E}, '{16'hFE8F,16'hFE90,16'hFE91,16'hFE92},
        '{16'hFE93,16'hFE94,16'hFE93,16'hFE94}, '{16'hFE95,16'hFE96,16'hFE97,16'hFE98},
        '{16'hFE99,16'hFE9A,16'hFE9B,16'hFE9C}, '{16'hFE9D,16'hFE9E,16'hFE9F,16'hFEA0},
        '{16'hFEA1,16'hFEA2,16'hFEA3,16'hFEA4}, '{16'hFEA5,16'hFEA6,16'hFEA7,16'hFEA8},
        '{16'hFEA9,16'hFEAA,16'hFEA9,16'hFEAA}, '{16'hFEAB,16'hFEAC,16'hFEAB,16'hFEAC},
        '{16'hFEAD,16'hFEAE,16'hFEAD,16'hFEAE}, '{16'hFEAF,16'hFEB0,16'hFEAF,16'hFEB0},
        '{16'hFEB1,16'hFEB2,16'hFEB3,16'hFEB4}, '{16'hFEB5,16'hFEB6,16'hFEB7,16'hFEB8},
        '{16'hFEB9,16'hFEBA,16'hFEBB,16'hFEBC}, '{16'hFEBD,16'hFEBE,16'hFEBF,16'hFEC0},
        '{16'hFEC1,16'hFEC2,16'hFEC3,16'hFEC4}, '{16'hFEC5,16'hFEC6,16'hFEC7,16'hFEC8},
        '{16'hFEC9,16'hFECA,16'hFECB,16'hFECC}, '{16'hFECD,16'hFECE,16'hFECF,16'hFED0},
        '{16'hFED1,16'hFED2,16'hFED3,16'hFED4}, '{16'hFED5,16'hFED6,16'hFED7,16'hFED8},
        '{16'hFED9,16'hFEDA,16'hFEDB,16'hFEDC}, '{16'hFEDD,16'hFEDE,16'hFEDF,16'hFEE0},
        '{16'hFEE1,16'hFEE2,16'hFEE3,16'hFEE4}, '{16'hFEE5,16'hFEE6,16'hFEE7,16'hFEE8},
        '{16'hFEE9,16'hFEEA,16'hFEEB,16'hFEEC}, '{16'hFEED,16'hFEEE,16'hFEED,16'hFEEE},
        '{16'hFEEF,16'hFEF0,16'hFEEF,16'hFEF0}, '{16'hFEF1,16'hFEF2,16'hFEF3,16'hFEF4}
    };

    function automatic logic is_letter(input logic [CP_W-1:0] c);
        return (c >= FIRST_LETTER && c <= GAP_LOW) || (c >= GAP_HIGH && c <= LAST_LETTER);
    endfunction

    function automatic logic [ROW_W-1:0] letter_row(input logic [CP_W-1:0] c);
        logic [CP_W-1:0] d;
        if (c <= GAP_LOW) begin
            d = c - FIRST_LETTER;
        end else begin
            d = c - GAP_HIGH + CP_W'(ROWS_LOW);
        end
        return d[ROW_W-1:0];
    endfunction

    function automatic logic joins_back(input logic [CP_W-1:0] c);
        return is_letter(c) && (c != HAMZA_CP);
    endfunction

    // right-joining letters do not connect to what follows
    function automatic logic joins_ahead(input logic [CP_W-1:0] c);
        logic r;
        case (c[11:0])
            12'h622, 12'h623, 12'h624, 12'h625, 12'h627,
            12'h629, 12'h62F, 12'h630, 12'h631, 12'h632,
            12'h648, 12'h649: r = 1'b0;
            default: r = 1'b1;
        endcase
        return joins_back(c) && r;
    endfunction

    function automatic logic [FORM_W-1:0] lam_alef_base(input logic [CP_W-1:0] c);
        logic [FORM_W-1:0] r;
        r = '0;
        if (c == ALEF_MADDA)   r = LIG_ALEF_MADDA;
        if (c == ALEF_HAMZA_A) r = LIG_ALEF_HAMZA_A;
        if (c == ALEF_HAMZA_B) r = LIG_ALEF_HAMZA_B;
        if (c == ALEF_CP)      r = LIG_ALEF;
        return r;
    endfunction

    function automatic logic [CP_W-1:0] shape(input logic [CP_W-1:0] c, input logic prev_j,
                                              input logic has_next,
                                              input logic [CP_W-1:0] nxt);
        logic       jb;
        logic       ja;
        logic [1:0] col;
        jb  = prev_j && joins_back(c);
        ja  = joins_ahead(c) && has_next && joins_back(nxt);
        col = {ja, jb};
        if (!is_letter(c)) begin
            return c;
        end
        return CP_W'(FORM_TABLE[letter_row(c)][col]);
    endfunction

endpackage

>>> rtl/acs_if.sv
interface acs_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        end_of_text;

    modport source (output valid, output code_point, output end_of_text, input ready);
    modport sink (input valid, input code_point, input end_of_text, output ready);
endinterface

interface acs_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] shaped_code_point;
    logic        final_out;

    modport source (output valid, output shaped_code_point, output final_out, input ready);
    modport sink (input valid, input shaped_code_point, input final_out, output ready);
endinterface

>>> rtl/arabic_contextual_shaper.sv
// Flow: a code point is held until its successor arrives; the transfer that releases its results
// writes them into the queue, and the output stage loads them from there once it is free.
// Throughput: one input per cycle while the queue is not full and each input yields at most one
// result; the single output port drains two-result inputs at one result per cycle while ready is high.
// Reset: synchronous active low; clears the hold, join flag, queue and output stage.
module arabic_contextual_shaper
    import acs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    acs_in_if.sink    i_in,
    acs_out_if.source o_out
);

    logic    w_push;
    logic    w_pop;
    t_job    w_push_job;
    t_job    w_head_job;
    t_q_stat w_q_stat;

    acs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    acs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    acs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_head_job),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("queue written while full");

    a_last_flushes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.end_of_text) |-> w_push)
        else $error("end of text produced no result");

    a_pop_needs_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop |-> !w_q_stat.empty) and (w_q_stat.empty && !o_out.valid |=> !o_out.valid))
        else $error("back stage loaded from empty queue");

endmodule

>>> rtl/acs_front.sv
module acs_front
    import acs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    acs_in_if.sink  i_in,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_job    o_job
);

    logic [CP_W-1:0] r_held_point, n_held_point;
    logic            r_held_valid, n_held_valid;
    logic            r_before_joins, n_before_joins;

    logic            w_xfer;
    logic [CP_W-1:0] w_c;
    logic            w_last;
    logic [FORM_W-1:0] w_lig;
    logic            w_is_lig;
    logic            w_bj_mid;
    t_result         w_held_res;
    t_result         w_last_res;

    assign i_in.ready = !i_q_stat.full;
    assign w_xfer     = i_in.valid && i_in.ready;
    assign w_c        = i_in.code_point;
    assign w_last     = i_in.end_of_text;

    always_comb begin
        w_lig    = lam_alef_base(w_c);
        w_is_lig = r_held_valid && (r_held_point == LAM_CP) && (w_lig != '0);
        w_bj_mid = r_held_valid ? joins_ahead(r_held_point) : r_before_joins;

        w_held_res.cp  = shape(r_held_point, r_before_joins, 1'b1, w_c);
        w_held_res.fin = 1'b0;
        w_last_res.cp  = shape(w_c, w_bj_mid, 1'b0, '0);
        w_last_res.fin = 1'b1;

        o_job        = '0;
        o_push       = 1'b0;
        n_held_point = r_held_point;
        n_held_valid = r_held_valid;
        n_before_joins = r_before_joins;

        if (w_is_lig) begin
            // isolated ligature is odd, final form is the next code
            o_job.first.cp  = CP_W'(w_lig) + CP_W'(r_before_joins);
            o_job.first.fin = w_last;
            o_job.two       = 1'b0;
            o_push          = w_xfer;
            if (w_xfer) begin
                n_held_point   = '0;
                n_held_valid   = 1'b0;
                n_before_joins = 1'b0;
            end
        end else begin
            o_job.first  = r_held_valid ? w_held_res : w_last_res;
            o_job.second = w_last_res;
            o_job.two    = r_held_valid && w_last;
            o_push       = w_xfer && (r_held_valid || w_last);
            if (w_xfer) begin
                if (w_last) begin
                    n_held_point   = '0;
                    n_held_valid   = 1'b0;
                    n_before_joins = 1'b0;
                end else begin
                    n_held_point   = w_c;
                    n_held_valid   = 1'b1;
                    n_before_joins = w_bj_mid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_point   <= '0;
            r_held_valid   <= 1'b0;
            r_before_joins <= 1'b0;
        end else begin
            r_held_point   <= n_held_point;
            r_held_valid   <= n_held_valid;
            r_before_joins <= n_before_joins;
        end
    end

endmodule

>>> rtl/acs_queue.sv
module acs_queue
    import acs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_wr;
    logic              w_rd;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_wr  = i_push && !o_stat.full;
    assign w_rd  = i_pop && !o_stat.empty;
    assign o_job = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/acs_back.sv
module acs_back
    import acs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job     i_job,
    input  t_q_stat  i_q_stat,
    output logic     o_pop,
    acs_out_if.source o_out
);

    t_job r_job, n_job;
    logic r_job_valid, n_job_valid;
    logic r_sel, n_sel;
    logic w_xfer;
    logic w_done;
    logic w_load;

    assign o_out.valid             = r_job_valid;
    assign o_out.shaped_code_point = r_sel ? r_job.second.cp : r_job.first.cp;
    assign o_out.final_out         = r_sel ? r_job.second.fin : r_job.first.fin;

    assign w_xfer = o_out.valid && o_out.ready;
    assign w_done = w_xfer && (r_sel || !r_job.two);
    assign w_load = !r_job_valid || w_done;
    assign o_pop  = w_load && !i_q_stat.empty;

    always_comb begin
        n_job       = r_job;
        n_job_valid = r_job_valid;
        n_sel       = r_sel;
        if (w_xfer && !w_done) begin
            n_sel = 1'b1;
        end
        if (w_load) begin
            n_job       = i_job;
            n_job_valid = !i_q_stat.empty;
            n_sel       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            r_sel       <= n_sel;
        end
    end

endmodule
